>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/fpcm_pkg.sv
// Types, codes and helpers for the PCM signaling step.
package fpcm_pkg;

    localparam int unsigned VEC_W   = 10;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned BITNO_W = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 2;
    // Shift that moves vector bit 4 to bit 1 of the length class.
    localparam int unsigned LCT_HIGH_SHIFT = 4 - 1;

    typedef enum logic [1:0] {
        TYPE_A = 2'd0,
        TYPE_B = 2'd1,
        TYPE_S = 2'd2,
        TYPE_M = 2'd3
    } t_port_type;

    typedef enum logic [2:0] {
        ACT_SIGNAL  = 3'd0,
        ACT_TEST    = 3'd1,
        ACT_MACLOOP = 3'd2,
        ACT_OFF     = 3'd3,
        ACT_WOFF    = 3'd4,
        ACT_JOIN    = 3'd5,
        ACT_NONE    = 3'd6
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORT_TYPE       = 3'd0,
        CFG_DUAL_ATTACH     = 3'd1,
        CFG_TREE_MODE       = 3'd2,
        CFG_WITHHOLD_A      = 3'd3,
        CFG_WITHHOLD_A_TREE = 3'd4
    } t_cfg_index;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_BIT   = 1'b1
    } t_command;

    // Signaling bit numbers that carry work.
    localparam logic [BITNO_W-1:0] BIT_TYPE   = 4'd3;
    localparam logic [BITNO_W-1:0] BIT_HOLD   = 4'd4;
    localparam logic [BITNO_W-1:0] BIT_LCT    = 4'd7;
    localparam logic [BITNO_W-1:0] BIT_RESULT = 4'd8;
    localparam logic [BITNO_W-1:0] BIT_MAC    = 4'd9;
    localparam logic [BITNO_W-1:0] BIT_JOIN   = 4'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        t_port_type port_type;
        logic       dual_attach;
        logic       tree_mode;
        logic       withhold_a;
        logic       withhold_a_tree;
    } t_cfg;

    typedef struct packed {
        logic [VEC_W-1:0] tx_vector;
        t_port_type       peer_type;
        logic             test_running;
        logic             withhold_flag;
        logic             error_monitor_fail;
        logic             undesirable;
        logic             illegal;
        logic [CNT_W-1:0] consecutive_failures;
        logic [CNT_W-1:0] failure_total;
    } t_state;

    typedef struct packed {
        t_action          action;
        logic [1:0]       signal_count;
        logic [1:0]       lct_length;
        logic [VEC_W-1:0] transmit_bits;
        t_port_type       neighbor_type;
        logic             undesirable;
        logic             illegal;
        logic             withholding;
        logic [CNT_W-1:0] total_failures;
    } t_result;

    // Test length class: bit 5 gives the low bit, bit 4 the high bit.
    function automatic logic [1:0] length_class(input logic [VEC_W-1:0] v);
        logic [VEC_W-1:0] hi;
        hi = v >> LCT_HIGH_SHIFT;
        return {hi[1], v[5]};
    endfunction

endpackage

>>> src/fpcm_step.sv
// Combinational next-state and result logic for one signaling beat.
module fpcm_step (
    input  fpcm_pkg::t_cfg                  i_cfg,
    input  fpcm_pkg::t_state                i_state,
    input  logic                            i_command,
    input  logic [fpcm_pkg::BITNO_W-1:0]    i_bit_number,
    input  logic [fpcm_pkg::VEC_W-1:0]      i_received_bits,
    input  logic                            i_lct_failed,
    output fpcm_pkg::t_state                o_state,
    output fpcm_pkg::t_result               o_result
);

    logic [1:0] w_len_tx;
    logic [1:0] w_len_rx;

    assign w_len_tx = fpcm_pkg::length_class(i_state.tx_vector);
    assign w_len_rx = fpcm_pkg::length_class(i_received_bits);

    always_comb begin
        fpcm_pkg::t_state  st;
        fpcm_pkg::t_action act;
        logic [1:0]        cnt;
        logic [1:0]        len;
        logic              type_a_hold;

        st   = i_state;
        act  = fpcm_pkg::ACT_NONE;
        cnt  = 2'd0;
        len  = 2'd0;
        type_a_hold = (i_cfg.port_type == fpcm_pkg::TYPE_A) &&
                      (i_cfg.withhold_a || (i_cfg.withhold_a_tree && i_cfg.tree_mode));

        if (i_command == fpcm_pkg::CMD_START) begin
            st.test_running = 1'b0;
            // bit 1 for S and M, bit 2 for B and M
            st.tx_vector = {{(fpcm_pkg::VEC_W-3){1'b0}},
                            i_cfg.port_type[0], i_cfg.port_type[1], 1'b0};
            act = fpcm_pkg::ACT_SIGNAL;
            cnt = 2'd3;
        end else begin
            case (i_bit_number)
                fpcm_pkg::BIT_TYPE: begin
                    st.peer_type = fpcm_pkg::t_port_type'({i_received_bits[1],
                                                           i_received_bits[2]});
                    st.undesirable = 1'b0;
                    st.illegal     = 1'b0;
                    case (i_cfg.port_type)
                        fpcm_pkg::TYPE_A: begin
                            st.tx_vector[3] = 1'b1;
                            st.undesirable  = (st.peer_type != fpcm_pkg::TYPE_B);
                        end
                        fpcm_pkg::TYPE_B: begin
                            st.tx_vector[3] = 1'b1;
                            st.undesirable  = (st.peer_type != fpcm_pkg::TYPE_A);
                        end
                        fpcm_pkg::TYPE_S: begin
                            st.tx_vector[3] = 1'b1;
                            st.undesirable  = (st.peer_type == fpcm_pkg::TYPE_A) ||
                                              (st.peer_type == fpcm_pkg::TYPE_B);
                        end
                        default: begin
                            if (st.peer_type == fpcm_pkg::TYPE_M) begin
                                st.illegal = 1'b1;
                            end else begin
                                st.tx_vector[3] = 1'b1;
                            end
                        end
                    endcase
                    act = fpcm_pkg::ACT_SIGNAL;
                    cnt = 2'd1;
                end
                fpcm_pkg::BIT_HOLD: begin
                    st.withhold_flag = ~(i_received_bits[3] | i_state.tx_vector[3]);
                    if (st.withhold_flag || type_a_hold) begin
                        st.tx_vector[5:4] = 2'b11;
                    end else if (i_state.error_monitor_fail) begin
                        st.tx_vector[4] = 1'b1;
                    end else if (i_state.failure_total != '0) begin
                        st.tx_vector[5] = 1'b1;
                    end
                    act = fpcm_pkg::ACT_SIGNAL;
                    cnt = 2'd3;
                end
                fpcm_pkg::BIT_LCT: begin
                    if (!i_state.test_running) begin
                        len = (w_len_tx > w_len_rx) ? w_len_tx : w_len_rx;
                        st.test_running = 1'b1;
                        act = fpcm_pkg::ACT_TEST;
                    end else begin
                        st.test_running = 1'b0;
                        if (i_lct_failed) begin
                            if (i_state.consecutive_failures != fpcm_pkg::CNT_MAX) begin
                                st.consecutive_failures = i_state.consecutive_failures + 1'b1;
                            end
                            if (i_state.failure_total != fpcm_pkg::CNT_MAX) begin
                                st.failure_total = i_state.failure_total + 1'b1;
                            end
                            st.tx_vector[7]       = 1'b1;
                            st.error_monitor_fail = 1'b1;
                        end else begin
                            st.consecutive_failures = '0;
                        end
                        act = fpcm_pkg::ACT_SIGNAL;
                        cnt = 2'd1;
                    end
                end
                fpcm_pkg::BIT_RESULT: begin
                    if (i_state.tx_vector[7] || i_received_bits[7]) begin
                        act = fpcm_pkg::ACT_OFF;
                    end else begin
                        act = fpcm_pkg::ACT_SIGNAL;
                        cnt = 2'd1;
                    end
                end
                fpcm_pkg::BIT_MAC: begin
                    if (!i_state.test_running && i_received_bits[8]) begin
                        st.test_running = 1'b1;
                        act = fpcm_pkg::ACT_MACLOOP;
                    end else begin
                        st.test_running = 1'b0;
                        if (i_state.withhold_flag || type_a_hold) begin
                            act = fpcm_pkg::ACT_WOFF;
                        end else begin
                            if (!i_cfg.dual_attach || i_cfg.port_type != fpcm_pkg::TYPE_A ||
                                i_cfg.tree_mode) begin
                                st.tx_vector[9] = 1'b1;
                            end
                            act = fpcm_pkg::ACT_SIGNAL;
                            cnt = 2'd1;
                        end
                    end
                end
                fpcm_pkg::BIT_JOIN: begin
                    st.error_monitor_fail = 1'b0;
                    act = fpcm_pkg::ACT_JOIN;
                end
                default: begin
                    act = fpcm_pkg::ACT_NONE;
                end
            endcase
        end

        o_state = st;
        o_result.action         = act;
        o_result.signal_count   = cnt;
        o_result.lct_length     = len;
        o_result.transmit_bits  = st.tx_vector;
        o_result.neighbor_type  = st.peer_type;
        o_result.undesirable    = st.undesirable;
        o_result.illegal        = st.illegal;
        o_result.withholding    = st.withhold_flag;
        o_result.total_failures = st.failure_total;
    end

endmodule

>>> src/fddi_pcm_signaling_step.sv
// Top level of the FDDI PCM transmitter signaling step.
// One input beat gives exactly one result beat. The beat is evaluated
// combinationally against the held connection state (transmit vector, neighbor
// type, test and withhold flags, failure counters), the state advances at
// the accepting edge, and the result lands in a one-deep output register.
// o_out_valid rises in the cycle after input acceptance; throughput is
// one beat per cycle, since o_in_ready stays high while the output register
// is empty or is being drained in the same cycle. A start beat (command 0)
// reloads the transmit vector from the own port type and asks for three
// bits; bit beats act on signaling bits 3, 4, 7, 8, 9 and 10, any other bit
// number returns action none and leaves the state alone. Both failure
// counters saturate at 255. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data; write it only while no beat is in flight.
// Indexes outside the register list are dropped.
`include "assert_macros.svh"

module fddi_pcm_signaling_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [fpcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpcm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [fpcm_pkg::BITNO_W-1:0]       i_bit_number,
    input  logic [fpcm_pkg::VEC_W-1:0]         i_received_bits,
    input  logic                               i_lct_failed,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [2:0]                         o_action,
    output logic [1:0]                         o_signal_count,
    output logic [1:0]                         o_lct_length,
    output logic [fpcm_pkg::VEC_W-1:0]         o_transmit_bits,
    output logic [1:0]                         o_neighbor_type,
    output logic                               o_undesirable,
    output logic                               o_illegal,
    output logic                               o_withholding,
    output logic [fpcm_pkg::CNT_W-1:0]         o_total_failures
);

    fpcm_pkg::t_cfg    r_cfg;
    fpcm_pkg::t_state  r_st;
    fpcm_pkg::t_state  n_st;
    fpcm_pkg::t_result r_out;
    fpcm_pkg::t_result w_res;
    logic              r_out_valid;
    logic              w_in_accept;

    // Take a new beat whenever the output register is free or draining now.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.port_type       <= fpcm_pkg::TYPE_A;
            r_cfg.dual_attach     <= 1'b1;
            r_cfg.tree_mode       <= 1'b0;
            r_cfg.withhold_a      <= 1'b0;
            r_cfg.withhold_a_tree <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpcm_pkg::CFG_PORT_TYPE:
                    r_cfg.port_type <= fpcm_pkg::t_port_type'(i_cfg_data[1:0]);
                fpcm_pkg::CFG_DUAL_ATTACH:     r_cfg.dual_attach     <= i_cfg_data[0];
                fpcm_pkg::CFG_TREE_MODE:       r_cfg.tree_mode       <= i_cfg_data[0];
                fpcm_pkg::CFG_WITHHOLD_A:      r_cfg.withhold_a      <= i_cfg_data[0];
                fpcm_pkg::CFG_WITHHOLD_A_TREE: r_cfg.withhold_a_tree <= i_cfg_data[0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Evaluate the beat against the held state.
    fpcm_step u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_st),
        .i_command       (i_command),
        .i_bit_number    (i_bit_number),
        .i_received_bits (i_received_bits),
        .i_lct_failed    (i_lct_failed),
        .o_state         (n_st),
        .o_result        (w_res)
    );

    // Connection state: advance only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_in_accept) begin
            r_st <= n_st;
        end
    end

    // Output register: load on accept, clear valid once the beat drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out.action;
    assign o_signal_count   = r_out.signal_count;
    assign o_lct_length     = r_out.lct_length;
    assign o_transmit_bits  = r_out.transmit_bits;
    assign o_neighbor_type  = r_out.neighbor_type;
    assign o_undesirable    = r_out.undesirable;
    assign o_illegal        = r_out.illegal;
    assign o_withholding    = r_out.withholding;
    assign o_total_failures = r_out.total_failures;

    // A start beat always asks for three bits on the next result.
    `ASSERT_NEXT(a_start_signals_three, i_clk, i_rst_n,
        w_in_accept && (i_command == fpcm_pkg::CMD_START),
        (o_action == fpcm_pkg::ACT_SIGNAL) && (o_signal_count == 2'd3))
    // The total failure count never goes down.
    `ASSERT_NEXT(a_total_monotonic, i_clk, i_rst_n, 1'b1,
        r_st.failure_total >= $past(r_st.failure_total))
    // A run of failures never exceeds the total.
    `ASSERT_IMPL(a_run_le_total, i_clk, i_rst_n, 1'b1,
        r_st.consecutive_failures <= r_st.failure_total)
    // Illegal connection is only flagged against an M neighbor.
    `ASSERT_IMPL(a_illegal_peer_m, i_clk, i_rst_n, r_st.illegal,
        r_st.peer_type == fpcm_pkg::TYPE_M)

endmodule
